// ===== sv/cmbq_pkg.sv =====
// shared types and constants for the class match bounded queue
`default_nettype none

package cmbq_pkg;

   localparam int ID_W  = 16;
   localparam int OCC_W = 5;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_TAKE   = 1'b1;

   typedef enum logic [1:0] {
      STAT_APPENDED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_TAKEN    = 2'd2,
      STAT_NO_MATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic append;
      logic scan_init;
      logic rotate;
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mode;
      logic empty;
      logic last_step;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/cmbq_ctrl.sv =====
// sequencing state machine for the class match bounded queue
`default_nettype none

module cmbq_ctrl import cmbq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output logic         rsp_valid,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   state_type state_ff, state_in;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= cmd.respond;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.mode == MODE_APPEND) begin
               cmd.append  = 1'b1;
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.empty) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rotate = 1'b1;
            if (sts.last_step) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== sv/cmbq_dp.sv =====
// slot registers, rotation network and result registers of the queue
`default_nettype none

module cmbq_dp import cmbq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CLASS_BITS  = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic                  req_mode,
   input  wire logic [ID_W-1:0]       req_entry_id,
   input  wire logic [CLASS_BITS-1:0] req_entry_class,
   output logic [1:0]                 rsp_status,
   output logic [ID_W-1:0]            rsp_taken_id,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   // latched transaction
   logic                  mode_ff;
   logic [ID_W-1:0]       id_ff;
   logic [CLASS_BITS-1:0] class_ff;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      steps_ff;
   logic                  found_ff;
   logic [ID_W-1:0]       taken_ff;

   logic [ID_W-1:0]       slot_id_ff    [QUEUE_DEPTH];
   logic [CLASS_BITS-1:0] slot_class_ff [QUEUE_DEPTH];

   logic                  full;
   logic                  hit;
   status_type            status_in;

   logic [1:0]            status_ff;
   logic [ID_W-1:0]       taken_out_ff;
   logic [OCC_W-1:0]      occ_ff;

   assign full = (count_ff == FULL_CNT);
   // first match seen at the head during the rotation
   assign hit  = cmd.rotate && !found_ff && (slot_class_ff[0] == class_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.append && !full) begin
         count_in = count_ff + ONE_CNT;
      end else if (hit) begin
         count_in = count_ff - ONE_CNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.scan_init) begin
            steps_ff <= count_ff;
         end else if (cmd.rotate) begin
            steps_ff <= steps_ff - ONE_CNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         id_ff    <= req_entry_id;
         class_ff <= req_entry_class;
      end
      if (hit) begin
         taken_ff <= slot_id_ff[0];
      end
   end

   // each slot takes its younger neighbor (all but the last), the recycled head, or an append
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      localparam logic [CNT_W-1:0] POS  = CNT_W'(i);
      localparam logic [CNT_W-1:0] NEXT = CNT_W'(i + 1);
      if (i < QUEUE_DEPTH - 1) begin : g_mid
         always_ff @(posedge clock) begin
            if (cmd.append && !full && (count_ff == POS)) begin
               slot_id_ff[i]    <= id_ff;
               slot_class_ff[i] <= class_ff;
            end else if (cmd.rotate && (NEXT < count_ff)) begin
               slot_id_ff[i]    <= slot_id_ff[i+1];
               slot_class_ff[i] <= slot_class_ff[i+1];
            end else if (cmd.rotate && (NEXT == count_ff) && !hit) begin
               slot_id_ff[i]    <= slot_id_ff[0];
               slot_class_ff[i] <= slot_class_ff[0];
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (cmd.append && !full && (count_ff == POS)) begin
               slot_id_ff[i]    <= id_ff;
               slot_class_ff[i] <= class_ff;
            end else if (cmd.rotate && (NEXT == count_ff) && !hit) begin
               slot_id_ff[i]    <= slot_id_ff[0];
               slot_class_ff[i] <= slot_class_ff[0];
            end
         end
      end
   end

   always_comb begin
      if (mode_ff == MODE_APPEND) begin
         status_in = full ? STAT_DROPPED : STAT_APPENDED;
      end else begin
         status_in = found_ff ? STAT_TAKEN : STAT_NO_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         status_ff    <= status_in;
         taken_out_ff <= (status_in == STAT_TAKEN) ? taken_ff : '0;
         occ_ff       <= OCC_W'(count_in);
      end
   end

   assign sts.mode      = mode_ff;
   assign sts.empty     = (count_ff == '0);
   assign sts.last_step = (steps_ff == ONE_CNT);

   assign rsp_status    = status_ff;
   assign rsp_taken_id  = taken_out_ff;
   assign rsp_occupancy = occ_ff;

endmodule

`default_nettype wire

// ===== sv/class_match_bounded_queue_top.sv =====
// top level of the class match bounded queue
//
// command channel: a transaction is taken at a rising edge with start high
// and busy low; req_mode 0 appends req_entry_id/req_entry_class at the tail,
// req_mode 1 takes the oldest held entry whose class equals req_entry_class
// result channel: rsp_valid is high for exactly one cycle per transaction and
// carries rsp_status, rsp_taken_id (zero unless an entry was taken) and
// rsp_occupancy (entries held after the transaction, low five bits)
// the receiver cannot stall; every result is taken in the cycle it shows
// an append, or a take on an empty queue, shows its result registered from
// the execute state and busy drops together with the strobe, so the next
// transaction can start while the result is on the ports
// on a take from a queue holding n entries, the held entries rotate once
// through the head slot, one entry per cycle, the first class match is
// pulled out at the head and every other entry is recycled to the tail,
// which leaves arrival order intact
// reset clears the fill count and the state machine; slot contents are not
// cleared, since only slots below the fill count are ever read
`default_nettype none

module class_match_bounded_queue_top import cmbq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CLASS_BITS  = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_mode,
   input  wire logic [ID_W-1:0]       req_entry_id,
   input  wire logic [CLASS_BITS-1:0] req_entry_class,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [ID_W-1:0]            rsp_taken_id,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   cmbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   cmbq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CLASS_BITS  (CLASS_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_entry_id    (req_entry_id),
      .req_entry_class (req_entry_class),
      .rsp_status      (rsp_status),
      .rsp_taken_id    (rsp_taken_id),
      .rsp_occupancy   (rsp_occupancy)
   );

   // one strobe per transaction, never back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // a result only follows a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in flight");

   // an accepted transaction keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a drop only happens at full occupancy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_DROPPED)) |->
         (rsp_occupancy == OCC_W'(QUEUE_DEPTH)))
      else $error("drop reported below full occupancy");

   // identifier is zero unless an entry was taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_TAKEN)) |-> (rsp_taken_id == '0))
      else $error("nonzero identifier without a take");

endmodule

`default_nettype wire
